/* hw/rtl/ffbma_pkg.sv */
// ffbma_pkg: shared types and constants of the first-fit block map allocator.
// Holds the item structs, map marks, status codes and default parameters.
// No dependencies.
package ffbma_pkg;

    localparam int DEF_BLOCKS      = 1024;
    localparam int DEF_BLOCK_BYTES = 256;

    // accumulator width: a heap span never exceeds 2^32 bytes
    localparam int ACC_W  = 33;
    localparam int PROD_W = 32;

    localparam logic [1:0] MARK_FREE   = 2'd0;
    localparam logic [1:0] MARK_USED   = 2'd1;
    localparam logic [1:0] MARK_BORDER = 2'd2;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_NULL    = 2'd1;
    localparam logic [1:0] ST_NOSPACE = 2'd2;
    localparam logic [1:0] ST_INVALID = 2'd3;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    typedef struct packed {
        logic        action;
        logic [31:0] request_bytes;
        logic [63:0] region_address;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [63:0] granted_address;
    } t_out_item;

endpackage

/* hw/rtl/ffbma_map.sv */
// ffbma_map: block map storage, one write port and one registered read port.
// Depends on ffbma_pkg.
module ffbma_map import ffbma_pkg::*; #(
    parameter int BLOCKS = DEF_BLOCKS
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((BLOCKS > 1) ? $clog2(BLOCKS) : 1)-1:0] i_waddr,
    input  logic [1:0]                            i_wdata,
    input  logic [((BLOCKS > 1) ? $clog2(BLOCKS) : 1)-1:0] i_raddr,
    output logic [1:0]                            o_rdata
);

    logic [1:0] r_mem [BLOCKS];
    logic [1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hw/rtl/ffbma_step.sv */
// ffbma_step: shared add-and-compare unit, advances a byte count by one block.
// Depends on ffbma_pkg.
module ffbma_step import ffbma_pkg::*; #(
    parameter int BLOCK_BYTES = DEF_BLOCK_BYTES
) (
    input  logic [ACC_W-1:0] i_acc,
    input  logic [ACC_W-1:0] i_target,
    output logic [ACC_W-1:0] o_sum,
    output logic             o_ge,
    output logic             o_eq
);

    localparam logic [ACC_W-1:0] STEP = ACC_W'(BLOCK_BYTES);

    assign o_sum = i_acc + STEP;
    assign o_ge  = (o_sum >= i_target);
    assign o_eq  = (o_sum == i_target);

endmodule

/* hw/rtl/first_fit_block_map_allocator.sv */
// first_fit_block_map_allocator: first-fit heap allocator over a block map.
// Depends on ffbma_pkg, ffbma_map, ffbma_step.
//
// channel   direction  handshake                        payload
// command   in         start high, busy low             i_item (t_in_item)
// result    out        o_done strobe, one cycle         o_result (t_out_item)
// config    in         i_cfg_valid and o_cfg_ready      i_cfg_data (base address)
//
// After reset the map is cleared one entry a cycle with busy high, first entry set to border.
// Allocate: marks the first free run that holds the request used, its last block border, and
// returns base + start * BLOCK_BYTES, or no-space. Free: checks the offset from the base,
// finds its block and a border before it, frees the used blocks, then the border if the next
// block is free. One map entry per cycle through one read port. The result strobes as busy
// falls; null requests in the cycle after accept with busy low. Results cannot be stalled.
module first_fit_block_map_allocator import ffbma_pkg::*; #(
    parameter int BLOCKS      = DEF_BLOCKS,
    parameter int BLOCK_BYTES = DEF_BLOCK_BYTES
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  t_in_item    i_item,
    output logic        o_done,
    output t_out_item   o_result,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [63:0] i_cfg_data
);

    localparam int IW = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
    localparam int CW = $clog2(BLOCKS + 1);
    localparam logic [CW-1:0] LIM  = CW'(BLOCKS);
    localparam logic [CW-1:0] LAST = CW'(BLOCKS - 1);
    localparam logic [63:0]   SPAN = 64'(BLOCKS) * 64'(BLOCK_BYTES);

    localparam logic [3:0] S_CLEAR    = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_A_SCAN   = 4'd2;
    localparam logic [3:0] S_A_MARK   = 4'd3;
    localparam logic [3:0] S_A_MUL    = 4'd4;
    localparam logic [3:0] S_A_ADD    = 4'd5;
    localparam logic [3:0] S_F_SUB    = 4'd6;
    localparam logic [3:0] S_F_RANGE  = 4'd7;
    localparam logic [3:0] S_F_SEARCH = 4'd8;
    localparam logic [3:0] S_F_PREV   = 4'd9;
    localparam logic [3:0] S_F_WALK   = 4'd10;
    localparam logic [3:0] S_F_TAIL   = 4'd11;

    logic [3:0]        r_state, n_state;
    logic [CW-1:0]     r_idx, n_idx;
    logic [CW-1:0]     r_start, n_start;
    logic [CW-1:0]     r_end, n_end;
    logic [ACC_W-1:0]  r_acc, n_acc;
    logic [ACC_W-1:0]  r_target, n_target;
    logic [63:0]       r_addr, n_addr;
    logic [63:0]       r_off, n_off;
    logic [PROD_W-1:0] r_prod, n_prod;
    logic [63:0]       r_base;
    logic              r_done, n_done;
    t_out_item         r_result, n_result;

    logic [CW-1:0]     w_idx_inc;
    logic [CW-1:0]     w_rd;
    logic [IW-1:0]     w_raddr;
    logic              w_we;
    logic [IW-1:0]     w_waddr;
    logic [1:0]        w_wdata;
    logic [1:0]        w_rdata;
    logic [ACC_W-1:0]  w_sum;
    logic              w_ge;
    logic              w_eq;
    logic [64:0]       w_diff;

    ffbma_map #(.BLOCKS(BLOCKS)) u_map (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    ffbma_step #(.BLOCK_BYTES(BLOCK_BYTES)) u_step (
        .i_acc    (r_acc),
        .i_target (r_target),
        .o_sum    (w_sum),
        .o_ge     (w_ge),
        .o_eq     (w_eq)
    );

    assign w_idx_inc   = r_idx + CW'(1);
    assign w_raddr     = (w_rd < LIM) ? w_rd[IW-1:0] : '0;
    assign w_diff      = {1'b0, r_addr} - {1'b0, r_base};
    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_done      = r_done;
    assign o_result    = r_result;

    always_comb begin
        n_state  = r_state;
        n_idx    = r_idx;
        n_start  = r_start;
        n_end    = r_end;
        n_acc    = r_acc;
        n_target = r_target;
        n_addr   = r_addr;
        n_off    = r_off;
        n_prod   = r_prod;
        n_done   = 1'b0;
        n_result = r_result;
        w_rd     = '0;
        w_we     = 1'b0;
        w_waddr  = r_idx[IW-1:0];
        w_wdata  = MARK_FREE;
        case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_wdata = (r_idx == '0) ? MARK_BORDER : MARK_FREE;
                if (r_idx == LAST) begin
                    n_state = S_IDLE;
                end else begin
                    n_idx = w_idx_inc;
                end
            end
            S_IDLE: begin
                if (start) begin
                    if (i_item.action == ACT_ALLOC) begin
                        if (i_item.request_bytes == '0) begin
                            n_done   = 1'b1;
                            n_result = '{status: ST_NULL, granted_address: '0};
                        end else begin
                            n_target = ACC_W'(i_item.request_bytes);
                            n_acc    = '0;
                            n_start  = '0;
                            n_idx    = '0;
                            n_state  = S_A_SCAN;
                        end
                    end else begin
                        if (i_item.region_address == '0) begin
                            n_done   = 1'b1;
                            n_result = '{status: ST_NULL, granted_address: '0};
                        end else begin
                            n_addr  = i_item.region_address;
                            n_state = S_F_SUB;
                        end
                    end
                end
            end
            S_A_SCAN: begin
                w_rd = w_idx_inc;
                if (w_rdata == MARK_FREE && w_ge) begin
                    n_end   = r_idx;
                    n_idx   = r_start;
                    n_state = S_A_MARK;
                end else if (r_idx == LAST) begin
                    n_done   = 1'b1;
                    n_result = '{status: ST_NOSPACE, granted_address: '0};
                    n_state  = S_IDLE;
                end else begin
                    n_idx = w_idx_inc;
                    if (w_rdata == MARK_FREE) begin
                        n_acc = w_sum;
                    end else begin
                        n_acc   = '0;
                        n_start = w_idx_inc;
                    end
                end
            end
            S_A_MARK: begin
                w_we    = 1'b1;
                w_wdata = (r_idx == r_end) ? MARK_BORDER : MARK_USED;
                if (r_idx == r_end) begin
                    n_state = S_A_MUL;
                end else begin
                    n_idx = w_idx_inc;
                end
            end
            S_A_MUL: begin
                n_prod  = PROD_W'(r_start) * PROD_W'(BLOCK_BYTES);
                n_state = S_A_ADD;
            end
            S_A_ADD: begin
                n_done   = 1'b1;
                n_result = '{status: ST_DONE, granted_address: r_base + 64'(r_prod)};
                n_state  = S_IDLE;
            end
            S_F_SUB: begin
                if (w_diff[64]) begin
                    n_done   = 1'b1;
                    n_result = '{status: ST_INVALID, granted_address: '0};
                    n_state  = S_IDLE;
                end else begin
                    n_off   = w_diff[63:0];
                    n_state = S_F_RANGE;
                end
            end
            S_F_RANGE: begin
                if (r_off == '0 || r_off > SPAN) begin
                    n_done   = 1'b1;
                    n_result = '{status: ST_INVALID, granted_address: '0};
                    n_state  = S_IDLE;
                end else begin
                    n_target = r_off[ACC_W-1:0];
                    n_acc    = '0;
                    n_idx    = '0;
                    n_state  = S_F_SEARCH;
                end
            end
            S_F_SEARCH: begin
                w_rd = r_idx;
                if (w_eq) begin
                    n_idx   = w_idx_inc;
                    n_state = S_F_PREV;
                end else if (w_ge) begin
                    n_done   = 1'b1;
                    n_result = '{status: ST_INVALID, granted_address: '0};
                    n_state  = S_IDLE;
                end else begin
                    n_acc = w_sum;
                    n_idx = w_idx_inc;
                end
            end
            S_F_PREV: begin
                w_rd = r_idx;
                if (w_rdata != MARK_BORDER) begin
                    n_done   = 1'b1;
                    n_result = '{status: ST_INVALID, granted_address: '0};
                    n_state  = S_IDLE;
                end else begin
                    n_state = S_F_WALK;
                end
            end
            S_F_WALK: begin
                w_rd = w_idx_inc;
                if (r_idx < LIM && w_rdata == MARK_USED) begin
                    w_we  = 1'b1;
                    n_idx = w_idx_inc;
                end else if (r_idx < LIM && w_rdata == MARK_BORDER && w_idx_inc < LIM) begin
                    n_state = S_F_TAIL;
                end else begin
                    n_done   = 1'b1;
                    n_result = '{status: ST_DONE, granted_address: '0};
                    n_state  = S_IDLE;
                end
            end
            S_F_TAIL: begin
                w_we     = (w_rdata == MARK_FREE);
                n_done   = 1'b1;
                n_result = '{status: ST_DONE, granted_address: '0};
                n_state  = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_idx   <= '0;
            r_done  <= 1'b0;
            r_base  <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_done  <= n_done;
            if (i_cfg_valid && o_cfg_ready) begin
                r_base <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_start  <= n_start;
        r_end    <= n_end;
        r_acc    <= n_acc;
        r_target <= n_target;
        r_addr   <= n_addr;
        r_off    <= n_off;
        r_prod   <= n_prod;
        r_result <= n_result;
    end

endmodule

/* hw/rtl/ffbma_checker.sv */
// ffbma_checker: port-level assertions for the allocator, bound to the top level.
// Depends on ffbma_pkg and first_fit_block_map_allocator.
module ffbma_checker import ffbma_pkg::*; (
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      start,
    input logic      busy,
    input logic      o_done,
    input t_out_item o_result
);

    a_accept_progress: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> (busy || o_done))
        else $error("accepted item neither in progress nor finished");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result shown while still busy");

    a_addr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.status != ST_DONE) |-> (o_result.granted_address == '0))
        else $error("nonzero address on failed request");

    a_busy_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(busy) |-> $past(start))
        else $error("busy raised without an item");

endmodule

bind first_fit_block_map_allocator ffbma_checker u_ffbma_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .start    (start),
    .busy     (busy),
    .o_done   (o_done),
    .o_result (o_result)
);
